[design/fprs_pkg.sv]
package fprs_pkg;

    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_ONES  = 11'h7FF;

    typedef enum logic [1:0] {
        SIGN_FROM_A = 2'd0,
        SIGN_KEEP   = 2'd1,
        SIGN_CLEAR  = 2'd2,
        SIGN_SET    = 2'd3
    } sign_mode_t;

    // operand pair after classification and denormal flushing
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        snan;
        logic [63:0] snan_value;
        logic        a_nan;
        logic        b_nan;
        logic        denorm;
        logic        pick_max;
        logic        magnitude;
        sign_mode_t  sign_mode;
    } fprs_class_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        choose_b;
        logic        snan;
        logic [63:0] snan_value;
        logic        denorm;
        sign_mode_t  sign_mode;
    } fprs_pick_t;

    function automatic logic is_nan(input logic [63:0] v);
        return (v[62:52] == EXP_ONES) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_denormal(input logic [63:0] v);
        return (v[62:52] == 11'd0) && (v[51:0] != 52'd0);
    endfunction

endpackage

[design/float64_range_select_top.sv]
// Double-precision range select (min/max with magnitude and sign control).
//
// Input channel: in_valid / in_stall carry operand_a, operand_b, pick_max,
// compare_magnitude and sign_mode; a transaction completes on a clock edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry selected_value, invalid_flag
// and denormal_flag, one result transaction per input transaction, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into denormals_are_zero; write
// it only while no transaction is in flight.
//
// Three register stages: classify/flush, compare, select/sign. Throughput
// is one transaction per cycle while out_stall is low. Each stage moves
// when its slot is empty or the one after it moves, so a stall on the
// output fills the pipe and then raises in_stall; nothing is dropped or
// repeated. Reset empties all stages and clears denormals_are_zero.
module float64_range_select_top
    import fprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        pick_max,
    input  logic        compare_magnitude,
    input  logic [1:0]  sign_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] selected_value,
    output logic        invalid_flag,
    output logic        denormal_flag
);

    logic        daz_reg;
    logic        daz_next;
    logic        v1;
    logic        v2;
    logic        adv1;
    logic        adv2;
    logic        adv3;
    fprs_class_t class_s1;
    fprs_pick_t  pick_s2;

    assign daz_next = cfg_wr_en ? cfg_wr_data : daz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            daz_reg <= 1'b0;
        else
            daz_reg <= daz_next;
    end

    assign adv3     = !out_valid || !out_stall;
    assign adv2     = !v2 || adv3;
    assign adv1     = !v1 || adv2;
    assign in_stall = !adv1;

    fprs_classify u_classify (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (adv1),
        .valid_in          (in_valid),
        .daz               (daz_reg),
        .operand_a         (operand_a),
        .operand_b         (operand_b),
        .pick_max          (pick_max),
        .compare_magnitude (compare_magnitude),
        .sign_mode         (sign_mode),
        .valid_out         (v1),
        .class_out         (class_s1)
    );

    fprs_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv2),
        .valid_in  (v1),
        .class_in  (class_s1),
        .valid_out (v2),
        .pick_out  (pick_s2)
    );

    fprs_select u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (adv3),
        .valid_in       (v2),
        .pick_in        (pick_s2),
        .valid_out      (out_valid),
        .selected_value (selected_value),
        .invalid_flag   (invalid_flag),
        .denormal_flag  (denormal_flag)
    );

    // input back-pressure only when every stage holds a transaction
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1 && v2 && out_valid))
        else $error("in_stall raised with an empty stage");

    a_snan_no_denorm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid_flag) |-> !denormal_flag)
        else $error("invalid and denormal flags both set");

    a_snan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid_flag) |-> selected_value[51])
        else $error("signaling NaN result not quieted");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2 && out_valid && out_stall) |=> v2)
        else $error("compare stage lost a transaction under stall");

endmodule

[design/fprs_classify.sv]
module fprs_classify
    import fprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        valid_in,
    input  logic        daz,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        pick_max,
    input  logic        compare_magnitude,
    input  logic [1:0]  sign_mode,
    output logic        valid_out,
    output fprs_class_t class_out
);

    logic        valid_reg;
    logic        valid_next;
    fprs_class_t class_reg;
    fprs_class_t class_next;
    logic        a_nan;
    logic        b_nan;
    logic        a_snan;
    logic        b_snan;
    logic        a_den;
    logic        b_den;

    always_comb
    begin
        a_nan  = is_nan(operand_a);
        b_nan  = is_nan(operand_b);
        a_snan = a_nan && !operand_a[51];
        b_snan = b_nan && !operand_b[51];
        a_den  = is_denormal(operand_a);
        b_den  = is_denormal(operand_b);

        class_next.a          = (a_den && daz) ? (operand_a & SIGN_BIT) : operand_a;
        class_next.b          = (b_den && daz) ? (operand_b & SIGN_BIT) : operand_b;
        class_next.snan       = a_snan || b_snan;
        class_next.snan_value = (a_snan ? operand_a : operand_b) | QUIET_BIT;
        class_next.a_nan      = a_nan;
        class_next.b_nan      = b_nan;
        class_next.denorm     = !daz && ((a_den && !b_nan) || (b_den && !a_nan));
        class_next.pick_max   = pick_max;
        class_next.magnitude  = compare_magnitude;
        class_next.sign_mode  = sign_mode_t'(sign_mode);

        valid_next = advance ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            class_reg <= class_next;
    end

    assign valid_out = valid_reg;
    assign class_out = class_reg;

endmodule

[design/fprs_compare.sv]
module fprs_compare
    import fprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        valid_in,
    input  fprs_class_t class_in,
    output logic        valid_out,
    output fprs_pick_t  pick_out
);

    logic       valid_reg;
    logic       valid_next;
    fprs_pick_t pick_reg;
    fprs_pick_t pick_next;
    logic       sa;
    logic       sb;
    logic       low_lt;
    logic       b_first;
    logic       choose_b;

    always_comb
    begin
        sa = class_in.a[63];
        sb = class_in.b[63];
        // with equal signs the full unsigned compare reduces to the low 63 bits
        low_lt  = class_in.a[62:0] < class_in.b[62:0];
        b_first = (class_in.magnitude ? 1'b0 : sa) ^ low_lt;

        if (class_in.b_nan)
            choose_b = 1'b0;
        else if (class_in.a_nan)
            choose_b = 1'b1;
        else if ((sa != sb) && !class_in.magnitude)
            choose_b = class_in.pick_max ? sa : !sa;
        else
            choose_b = class_in.pick_max ? b_first : !b_first;

        pick_next.a          = class_in.a;
        pick_next.b          = class_in.b;
        pick_next.choose_b   = choose_b;
        pick_next.snan       = class_in.snan;
        pick_next.snan_value = class_in.snan_value;
        pick_next.denorm     = class_in.denorm;
        pick_next.sign_mode  = class_in.sign_mode;

        valid_next = advance ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pick_reg <= pick_next;
    end

    assign valid_out = valid_reg;
    assign pick_out  = pick_reg;

endmodule

[design/fprs_select.sv]
module fprs_select
    import fprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        valid_in,
    input  fprs_pick_t  pick_in,
    output logic        valid_out,
    output logic [63:0] selected_value,
    output logic        invalid_flag,
    output logic        denormal_flag
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] value_reg;
    logic [63:0] value_next;
    logic        invalid_reg;
    logic        invalid_next;
    logic        denorm_reg;
    logic        denorm_next;
    logic [63:0] z;
    logic [63:0] z_signed;

    always_comb
    begin
        z = pick_in.choose_b ? pick_in.b : pick_in.a;

        case (pick_in.sign_mode)
            SIGN_FROM_A: z_signed = {pick_in.a[63], z[62:0]};
            SIGN_KEEP:   z_signed = z;
            SIGN_CLEAR:  z_signed = z & ~SIGN_BIT;
            default:     z_signed = z | SIGN_BIT;
        endcase

        // signaling NaN bypasses sign control and suppresses the denormal flag
        value_next   = pick_in.snan ? pick_in.snan_value : z_signed;
        invalid_next = pick_in.snan;
        denorm_next  = !pick_in.snan && pick_in.denorm;

        valid_next = advance ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg   <= value_next;
            invalid_reg <= invalid_next;
            denorm_reg  <= denorm_next;
        end
    end

    assign valid_out      = valid_reg;
    assign selected_value = value_reg;
    assign invalid_flag   = invalid_reg;
    assign denormal_flag  = denorm_reg;

endmodule
